/* design/block_average_downscaler_defines.svh */
// Assertion macros for the block average downscaler checker.
// No dependencies; expects clk and rst in the scope where they are used.
`ifndef BLOCK_AVERAGE_DOWNSCALER_DEFINES_SVH
`define BLOCK_AVERAGE_DOWNSCALER_DEFINES_SVH

// Checked only while out of reset.
`define BAVG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define BAVG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bavg_pkg.sv */
// Shared types and constants for the block average downscaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bavg_pkg;

  localparam int MAX_ICON_COLS_DEF = 64;
  localparam int MAX_BLOCK_DEF     = 64;
  localparam int MAX_WIDTH_DEF     = 4096;

  localparam int HEIGHT_LIMIT   = 4096;
  localparam int ICON_ROW_LIMIT = 64;
  localparam int ROWW           = 12;

  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [6:0]  RST_BLOCK_SIZE   = 7'd8;
  localparam logic [6:0]  RST_ICON_ROWS    = 7'd32;
  localparam logic [6:0]  RST_ICON_COLS    = 7'd32;

  // output queue
  localparam int QDEPTH = 8;
  localparam int QPW    = 3;
  localparam int QCW    = 4;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_BLOCK_SIZE   = 3'd2,
    REG_ICON_ROWS    = 3'd3,
    REG_ICON_COLS    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEQ_COL,
    SEQ_COL_WAIT,
    SEQ_ROW,
    SEQ_ROW_WAIT,
    SEQ_RECIP,
    SEQ_RECIP_WAIT,
    SEQ_READY
  } seq_state_t;

  typedef struct packed {
    logic       hit;
    logic       first;
    logic       emit;
    logic       last_icon;
    logic [5:0] row;
    logic [5:0] col;
  } beat_ctrl_t;

  typedef struct packed {
    logic [7:0] pix;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

/* design/bavg_div.sv */
// Shared serial restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bavg_div #(
  parameter int NW = 33,
  parameter int DW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient,
  output logic [DW-1:0]      remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] dvs;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [NW-1:0] quo_next;
  logic [DW-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, quo[NW-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
    quo_next = {quo[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NW);
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

/* design/bavg_pos.sv */
// Config registers, raster position and block position counters, realign sequencer.
// Depends on bavg_pkg and bavg_div.
`timescale 1ns / 1ps
`default_nettype none

module bavg_pos #(
  parameter int MAX_ICON_COLS = bavg_pkg::MAX_ICON_COLS_DEF,
  parameter int MAX_BLOCK     = bavg_pkg::MAX_BLOCK_DEF,
  parameter int MAX_WIDTH     = bavg_pkg::MAX_WIDTH_DEF,
  parameter int COLW          = 12,
  parameter int BSW           = 7,
  parameter int IDXW          = 6,
  parameter int RECW          = 32,
  parameter int DVW           = 33,
  parameter int DIVW          = 14
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [12:0]         cfg_data,
  input  wire logic                step,
  output logic                     aligned,
  output bavg_pkg::beat_ctrl_t     ctrl,
  output logic [IDXW-1:0]          idx,
  output logic [RECW-1:0]          recip,
  output logic                     bs_one
);

  localparam int ROWW = bavg_pkg::ROWW;

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [6:0]  block_size;
  logic [6:0]  icon_rows;
  logic [6:0]  icon_cols;

  logic [15:0]     w16;
  logic [COLW:0]   w;
  logic [12:0]     h;
  logic [8:0]      bs9;
  logic [BSW-1:0]  bs;
  logic [6:0]      nr;
  logic [8:0]      nc;
  logic [DIVW-1:0] dsq;

  logic [COLW-1:0] col;
  logic [COLW-1:0] bc;
  logic [BSW-1:0]  ic;
  logic [ROWW-1:0] row;
  logic [ROWW-1:0] br;
  logic [BSW-1:0]  ir;

  logic [COLW:0]   col_inc;
  logic [ROWW:0]   row_inc;
  logic [BSW:0]    ic_inc;
  logic [BSW:0]    ir_inc;

  bavg_pkg::seq_state_t state, state_next;

  logic            div_start;
  logic [DVW-1:0]  div_dividend;
  logic [DIVW-1:0] div_divisor;
  logic            div_done;
  logic [DVW-1:0]  div_quo;
  logic [DIVW-1:0] div_rem;
  logic [DVW-1:0]  recip_num;

  logic cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bavg_pkg::RST_IMAGE_WIDTH;
      image_height <= bavg_pkg::RST_IMAGE_HEIGHT;
      block_size   <= bavg_pkg::RST_BLOCK_SIZE;
      icon_rows    <= bavg_pkg::RST_ICON_ROWS;
      icon_cols    <= bavg_pkg::RST_ICON_COLS;
    end else if (cfg_wr) begin
      unique case (bavg_pkg::cfg_reg_t'(cfg_index))
        bavg_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bavg_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        bavg_pkg::REG_BLOCK_SIZE:   block_size   <= cfg_data[6:0];
        bavg_pkg::REG_ICON_ROWS:    icon_rows    <= cfg_data[6:0];
        bavg_pkg::REG_ICON_COLS:    icon_cols    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // effective limits: zero reads as one for width, height and block size; oversize saturates
  always_comb begin
    if (image_width == '0) begin
      w16 = 16'd1;
    end else if ({3'b0, image_width} > 16'(MAX_WIDTH)) begin
      w16 = 16'(MAX_WIDTH);
    end else begin
      w16 = {3'b0, image_width};
    end
    w = w16[COLW:0];

    if (image_height == '0) begin
      h = 13'd1;
    end else if (image_height > 13'(bavg_pkg::HEIGHT_LIMIT)) begin
      h = 13'(bavg_pkg::HEIGHT_LIMIT);
    end else begin
      h = image_height;
    end

    if (block_size == '0) begin
      bs9 = 9'd1;
    end else if ({2'b0, block_size} > 9'(MAX_BLOCK)) begin
      bs9 = 9'(MAX_BLOCK);
    end else begin
      bs9 = {2'b0, block_size};
    end
    bs = bs9[BSW-1:0];

    nr = (icon_rows > 7'(bavg_pkg::ICON_ROW_LIMIT)) ? 7'(bavg_pkg::ICON_ROW_LIMIT)
                                                    : icon_rows;
    nc = ({2'b0, icon_cols} > 9'(MAX_ICON_COLS)) ? 9'(MAX_ICON_COLS) : {2'b0, icon_cols};
  end

  assign dsq       = DIVW'(bs) * DIVW'(bs);
  assign bs_one    = (bs == BSW'(1));
  assign recip_num = (DVW'(1) << RECW) + DVW'(dsq) - DVW'(1);

  // beat control for the pixel at the current position
  always_comb begin
    ctrl.hit       = (16'(bc) < 16'(nc)) && (16'(br) < 16'(nr));
    ctrl.first     = (ic == '0) && (ir == '0);
    ctrl.emit      = ctrl.hit && (ic == bs - BSW'(1)) && (ir == bs - BSW'(1));
    ctrl.last_icon = (16'(br) == 16'(nr) - 16'd1) && (16'(bc) == 16'(nc) - 16'd1);
    ctrl.row       = 6'(br);
    ctrl.col       = 6'(bc);
  end

  assign idx = IDXW'(bc);

  assign col_inc = {1'b0, col} + (COLW+1)'(1);
  assign row_inc = {1'b0, row} + (ROWW+1)'(1);
  assign ic_inc  = {1'b0, ic} + (BSW+1)'(1);
  assign ir_inc  = {1'b0, ir} + (BSW+1)'(1);

  // realign sequencer: block column/row and reciprocal rederived after reset and any config write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bavg_pkg::SEQ_COL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bavg_pkg::SEQ_COL:        state_next = bavg_pkg::SEQ_COL_WAIT;
      bavg_pkg::SEQ_COL_WAIT:   if (div_done) state_next = bavg_pkg::SEQ_ROW;
      bavg_pkg::SEQ_ROW:        state_next = bavg_pkg::SEQ_ROW_WAIT;
      bavg_pkg::SEQ_ROW_WAIT:   if (div_done) state_next = bavg_pkg::SEQ_RECIP;
      bavg_pkg::SEQ_RECIP:      state_next = bavg_pkg::SEQ_RECIP_WAIT;
      bavg_pkg::SEQ_RECIP_WAIT: if (div_done) state_next = bavg_pkg::SEQ_READY;
      bavg_pkg::SEQ_READY:      state_next = bavg_pkg::SEQ_READY;
      default:                  state_next = bavg_pkg::SEQ_COL;
    endcase
    if (cfg_wr) begin
      state_next = bavg_pkg::SEQ_COL;
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVW'(col);
    div_divisor  = DIVW'(bs);
    aligned      = 1'b0;
    unique case (state)
      bavg_pkg::SEQ_COL: begin
        div_start = 1'b1;
      end
      bavg_pkg::SEQ_ROW: begin
        div_start    = 1'b1;
        div_dividend = DVW'(row);
      end
      bavg_pkg::SEQ_RECIP: begin
        div_start    = 1'b1;
        div_dividend = recip_num;
        div_divisor  = dsq;
      end
      bavg_pkg::SEQ_READY: begin
        aligned = 1'b1;
      end
      default: ;
    endcase
  end

  bavg_div #(
    .NW (DVW),
    .DW (DIVW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      bc  <= '0;
      br  <= '0;
      ic  <= '0;
      ir  <= '0;
    end else if (step) begin
      if (col_inc >= w) begin
        col <= '0;
        bc  <= '0;
        ic  <= '0;
        if (row_inc >= {1'b0, h[ROWW:0]} || row_inc >= (ROWW+1)'(h)) begin
          row <= '0;
          br  <= '0;
          ir  <= '0;
        end else begin
          row <= row_inc[ROWW-1:0];
          if (ir_inc == {1'b0, bs}) begin
            ir <= '0;
            br <= br + ROWW'(1);
          end else begin
            ir <= ir_inc[BSW-1:0];
          end
        end
      end else begin
        col <= col_inc[COLW-1:0];
        if (ic_inc == {1'b0, bs}) begin
          ic <= '0;
          bc <= bc + COLW'(1);
        end else begin
          ic <= ic_inc[BSW-1:0];
        end
      end
    end else if (div_done) begin
      if (state == bavg_pkg::SEQ_COL_WAIT) begin
        bc <= div_quo[COLW-1:0];
        ic <= div_rem[BSW-1:0];
      end else if (state == bavg_pkg::SEQ_ROW_WAIT) begin
        br <= div_quo[ROWW-1:0];
        ir <= div_rem[BSW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_done && state == bavg_pkg::SEQ_RECIP_WAIT) begin
      recip <= div_quo[RECW-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/bavg_accum.sv */
// Column sum store with read-modify-write pipeline and reciprocal mean stage.
// Depends on bavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bavg_accum #(
  parameter int DEPTH = bavg_pkg::MAX_ICON_COLS_DEF,
  parameter int IDXW  = 6,
  parameter int SUMW  = 20,
  parameter int RECW  = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire bavg_pkg::beat_ctrl_t ctrl,
  input  wire logic [IDXW-1:0]      idx,
  input  wire logic [7:0]           pixel,
  input  wire logic [RECW-1:0]      recip,
  input  wire logic                 bs_one,
  output logic                      res_valid,
  output bavg_pkg::out_item_t       res,
  output logic [1:0]                pend
);

  localparam int PW = SUMW + RECW;

  logic [SUMW-1:0] sums [DEPTH];

  logic                 s1_valid;
  bavg_pkg::beat_ctrl_t s1_ctrl;
  logic [IDXW-1:0]      s1_idx;
  logic [7:0]           s1_pix;
  logic [SUMW-1:0]      rd_data;
  logic                 fwd_hit;
  logic [SUMW-1:0]      fwd_data;

  logic [SUMW-1:0] base;
  logic [SUMW-1:0] wr_data;
  logic            wr_en;

  logic                 s2_valid;
  bavg_pkg::beat_ctrl_t s2_ctrl;
  logic [SUMW-1:0]      s2_sum;
  logic [PW-1:0]        product;

  logic                 s3_valid;
  bavg_pkg::beat_ctrl_t s3_ctrl;
  logic [PW-1:0]        s3_prod;
  logic [7:0]           s3_low;

  // a write in the read cycle to the same entry is not yet in the read data
  assign base    = fwd_hit ? fwd_data : rd_data;
  assign wr_en   = s1_valid;
  assign wr_data = s1_ctrl.first ? SUMW'(s1_pix) : base + SUMW'(s1_pix);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sums[s1_idx] <= wr_data;
    end
    if (step && ctrl.hit) begin
      rd_data <= sums[idx];
    end
  end

  always_ff @(posedge clk) begin
    fwd_hit  <= wr_en && (s1_idx == idx);
    fwd_data <= wr_data;
    s1_ctrl  <= ctrl;
    s1_idx   <= idx;
    s1_pix   <= pixel;
    s2_ctrl  <= s1_ctrl;
    s2_sum   <= wr_data;
    s3_ctrl  <= s2_ctrl;
    s3_prod  <= product;
    s3_low   <= s2_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= step && ctrl.hit;
      s2_valid <= s1_valid && s1_ctrl.emit;
      s3_valid <= s2_valid;
    end
  end

  // sum times ceil(2^RECW / bs^2), exact for sums up to 255 * bs^2
  assign product = PW'(s2_sum) * PW'(recip);

  assign res_valid = s3_valid;
  assign res.pix   = bs_one ? s3_low : s3_prod[RECW+7:RECW];
  assign res.row   = s3_ctrl.row;
  assign res.col   = s3_ctrl.col;
  assign res.last  = s3_ctrl.last_icon;

  assign pend = 2'(s1_valid && s1_ctrl.emit) + 2'(s2_valid) + 2'(s3_valid);

endmodule

`default_nettype wire

/* design/bavg_outq.sv */
// Output queue between the mean pipeline and the result channel.
// Depends on bavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bavg_outq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bavg_pkg::out_item_t push_data,
  output logic                     valid,
  input  wire logic                ready,
  output bavg_pkg::out_item_t      data,
  output logic [bavg_pkg::QCW-1:0] count
);

  localparam int QPW = bavg_pkg::QPW;
  localparam int QCW = bavg_pkg::QCW;

  bavg_pkg::out_item_t q [bavg_pkg::QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic           pop;

  assign valid = (count != '0);
  assign pop   = valid && ready;
  assign data  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/block_average_downscaler.sv */
// Block average downscaler, top level.
// Throughput one pixel per cycle while in_ready is high, which it is not during realign
// nor when a beat completing a block finds no free queue slot. An icon pixel passes the
// sum store read, write-back, multiply and output queue on its way to out_valid. Reset and
// each config write start a realign pass on the serial divider; column sums are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module block_average_downscaler #(
  parameter int MAX_ICON_COLS = bavg_pkg::MAX_ICON_COLS_DEF,
  parameter int MAX_BLOCK     = bavg_pkg::MAX_BLOCK_DEF,
  parameter int MAX_WIDTH     = bavg_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       icon_pixel,
  output logic [5:0]       icon_row,
  output logic [5:0]       icon_col,
  output logic             last_of_icon,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int COLW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int BSW   = $clog2(MAX_BLOCK + 1);
  localparam int LB    = $clog2(MAX_BLOCK);
  localparam int SUMW  = 8 + 2 * LB;
  localparam int RECW  = 8 + 4 * LB;
  localparam int DIVW  = 2 * BSW;
  localparam int DVA   = (RECW + 1 > COLW) ? RECW + 1 : COLW;
  localparam int DVW   = (DVA > bavg_pkg::ROWW) ? DVA : bavg_pkg::ROWW;
  localparam int IDXW  = (MAX_ICON_COLS > 1) ? $clog2(MAX_ICON_COLS) : 1;
  localparam int QCW   = bavg_pkg::QCW;

  logic                 aligned;
  bavg_pkg::beat_ctrl_t ctrl;
  logic [IDXW-1:0]      idx;
  logic [RECW-1:0]      recip;
  logic                 bs_one;
  logic                 step;
  logic                 res_valid;
  bavg_pkg::out_item_t  res;
  logic [1:0]           pend;
  bavg_pkg::out_item_t  head;
  logic [QCW-1:0]       q_count;
  logic                 room;

  // a beat that completes a block needs a queue slot beyond those already claimed
  assign room     = ((QCW+1)'(q_count) + (QCW+1)'(pend)) < (QCW+1)'(bavg_pkg::QDEPTH);
  assign in_ready = aligned && (!ctrl.emit || room);
  assign step     = in_valid && in_ready;

  bavg_pos #(
    .MAX_ICON_COLS (MAX_ICON_COLS),
    .MAX_BLOCK     (MAX_BLOCK),
    .MAX_WIDTH     (MAX_WIDTH),
    .COLW          (COLW),
    .BSW           (BSW),
    .IDXW          (IDXW),
    .RECW          (RECW),
    .DVW           (DVW),
    .DIVW          (DIVW)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .aligned   (aligned),
    .ctrl      (ctrl),
    .idx       (idx),
    .recip     (recip),
    .bs_one    (bs_one)
  );

  bavg_accum #(
    .DEPTH (MAX_ICON_COLS),
    .IDXW  (IDXW),
    .SUMW  (SUMW),
    .RECW  (RECW)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .ctrl      (ctrl),
    .idx       (idx),
    .pixel     (pixel),
    .recip     (recip),
    .bs_one    (bs_one),
    .res_valid (res_valid),
    .res       (res),
    .pend      (pend)
  );

  bavg_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .valid     (out_valid),
    .ready     (out_ready),
    .data      (head),
    .count     (q_count)
  );

  assign icon_pixel   = head.pix;
  assign icon_row     = head.row;
  assign icon_col     = head.col;
  assign last_of_icon = head.last;

endmodule

`default_nettype wire

/* design/bavg_check.sv */
// Port-level checker for the block average downscaler, bound to the top level.
// Depends on block_average_downscaler_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "block_average_downscaler_defines.svh"

module bavg_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] icon_pixel,
  input wire logic [5:0] icon_row,
  input wire logic [5:0] icon_col,
  input wire logic       last_of_icon,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready
);

  // a stalled result beat holds
  `BAVG_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(icon_pixel) && $stable(icon_row) && $stable(icon_col) && $stable(last_of_icon)), "stalled result changed")

  // reset leaves the block realigning with an empty queue
  `BAVG_ASSERT_RST(a_reset_quiet, rst |=> (!in_ready && !out_valid), "not quiet after reset")

  // any config write starts a realign pass, so pixels are held off
  `BAVG_ASSERT(a_cfg_realign, (cfg_valid && cfg_ready) |=> !in_ready, "pixel taken during realign")

  // a result into an empty queue traces back to a pixel beat through the accumulator stages and the queue
  `BAVG_ASSERT(a_out_cause, $rose(out_valid) |-> $past((in_valid && in_ready), 4), "result without pixel beat")

endmodule

bind block_average_downscaler bavg_check u_check (.*);

`default_nettype wire
